/* src/rcfs_pkg.sv */
// Shared widths, register indexes and reset values for the RGB colour fade sequencer.
`default_nettype none

package rcfs_pkg;

  localparam int unsigned DEF_NUM_COLORS = 7;
  localparam int unsigned DEF_FADE_STEPS = 512;

  localparam int unsigned COLOR_W   = 3;
  localparam int unsigned MAX_COLORS = 1 << COLOR_W;
  localparam int unsigned NUM_COMP  = 3;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned PAL_W     = 21;
  localparam int unsigned PAL_EXT_W = MAX_COLORS * NUM_COMP;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned SCALE_W   = LEVEL_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCALE_W-1:0] FULL_SCALE = SCALE_W'(1024);

  localparam logic [TICK_W-1:0] FADE_TICKS_RST = TICK_W'(5);
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST = TICK_W'(5000);
  localparam logic [PAL_W-1:0]  PALETTE_RST    = PAL_W'(2025233);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_TICKS = 2'd0,
    CFG_HOLD_TICKS = 2'd1,
    CFG_PALETTE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0] fade_ticks;
    logic [TICK_W-1:0] hold_ticks;
  } tick_cfg_t;

endpackage

`default_nettype wire

/* src/rgb_color_fade_sequencer.sv */
// Top level of the RGB colour fade sequencer: config registers and result register.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, tick_i            | in
//  out     | out_valid_o, out_stall_i, levels, colour  | out
//  cfg     | cfg_valid_i, cfg_ready_o, index, data     | in
//
// One request per clock when not stalled; its result goes to the result register.
// The result shows the sequencer state before the request's tick is applied.
// in_stall_o is high only while a held result is stalled at the output.
// Reset loads the default fade and hold counts and palette, colour 0, step 0, fading.
`default_nettype none

module rgb_color_fade_sequencer #(
  parameter int unsigned NUM_COLORS = rcfs_pkg::DEF_NUM_COLORS,
  parameter int unsigned FADE_STEPS = rcfs_pkg::DEF_FADE_STEPS,
  localparam int unsigned STEP_W    = $clog2(FADE_STEPS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           tick_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [rcfs_pkg::LEVEL_W-1:0]        red_level_o,
  output logic [rcfs_pkg::LEVEL_W-1:0]        green_level_o,
  output logic [rcfs_pkg::LEVEL_W-1:0]        blue_level_o,
  output logic [rcfs_pkg::COLOR_W-1:0]        from_color_o,
  output logic [STEP_W-1:0]                   fade_step_o,
  output logic                                holding_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rcfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rcfs_pkg::PAL_W-1:0]     cfg_data_i
);
  import rcfs_pkg::*;

  tick_cfg_t          tcfg_q;
  logic [PAL_W-1:0]   palette_q;
  cfg_idx_e           cfg_idx;

  logic               accept;
  logic [COLOR_W-1:0] color;
  logic [STEP_W-1:0]  step;
  logic               hold;
  logic [NUM_COMP-1:0][LEVEL_W-1:0] levels;

  logic               out_valid_q, out_valid_d;
  logic [NUM_COMP-1:0][LEVEL_W-1:0] levels_q;
  logic [COLOR_W-1:0] color_q;
  logic [STEP_W-1:0]  step_q;
  logic               hold_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcfg_q.fade_ticks <= FADE_TICKS_RST;
      tcfg_q.hold_ticks <= HOLD_TICKS_RST;
      palette_q         <= PALETTE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        CFG_FADE_TICKS: tcfg_q.fade_ticks <= cfg_data_i[TICK_W-1:0];
        CFG_HOLD_TICKS: tcfg_q.hold_ticks <= cfg_data_i[TICK_W-1:0];
        CFG_PALETTE:    palette_q         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  rcfs_seq #(
    .NUM_COLORS (NUM_COLORS),
    .FADE_STEPS (FADE_STEPS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept & tick_i),
    .cfg_i     (tcfg_q),
    .color_o   (color),
    .step_o    (step),
    .hold_o    (hold)
  );

  rcfs_level #(
    .NUM_COLORS (NUM_COLORS),
    .FADE_STEPS (FADE_STEPS)
  ) u_level (
    .palette_i (palette_q),
    .color_i   (color),
    .step_i    (step),
    .levels_o  (levels)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      levels_q <= levels;
      color_q  <= color;
      step_q   <= step;
      hold_q   <= hold;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = levels_q[0];
  assign green_level_o = levels_q[1];
  assign blue_level_o  = levels_q[2];
  assign from_color_o  = color_q;
  assign fade_step_o   = step_q;
  assign holding_o     = hold_q;

endmodule

`default_nettype wire

/* src/rcfs_seq.sv */
// Palette index, fade step, hold flag and tick counter of the fade sequencer.
`default_nettype none

module rcfs_seq #(
  parameter int unsigned NUM_COLORS = rcfs_pkg::DEF_NUM_COLORS,
  parameter int unsigned FADE_STEPS = rcfs_pkg::DEF_FADE_STEPS,
  localparam int unsigned STEP_W    = $clog2(FADE_STEPS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire rcfs_pkg::tick_cfg_t          cfg_i,
  output logic [rcfs_pkg::COLOR_W-1:0]      color_o,
  output logic [STEP_W-1:0]                 step_o,
  output logic                              hold_o
);
  import rcfs_pkg::*;

  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(FADE_STEPS - 1);
  localparam logic [COLOR_W-1:0] LAST_COLOR = COLOR_W'(NUM_COLORS - 1);

  logic [COLOR_W-1:0] color_q, color_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               hold_q, hold_d;
  logic [TICK_W-1:0]  tick_q, tick_d;

  logic [TICK_W:0]    count;
  logic [TICK_W:0]    fade_lim;
  logic [TICK_W:0]    hold_lim;

  assign count    = {1'b0, tick_q} + (TICK_W+1)'(1);
  assign fade_lim = (cfg_i.fade_ticks == '0) ? (TICK_W+1)'(1) : {1'b0, cfg_i.fade_ticks};
  assign hold_lim = (cfg_i.hold_ticks == '0) ? (TICK_W+1)'(1) : {1'b0, cfg_i.hold_ticks};

  always_comb begin
    color_d = color_q;
    step_d  = step_q;
    hold_d  = hold_q;
    tick_d  = tick_q;
    if (advance_i) begin
      if (!hold_q) begin
        if (count >= fade_lim) begin
          tick_d = '0;
          if (step_q == LAST_STEP) begin
            hold_d = 1'b1;
          end else begin
            step_d = step_q + STEP_W'(1);
          end
        end else begin
          tick_d = count[TICK_W-1:0];
        end
      end else begin
        if (count >= hold_lim) begin
          tick_d  = '0;
          hold_d  = 1'b0;
          step_d  = '0;
          color_d = (color_q == LAST_COLOR) ? '0 : color_q + COLOR_W'(1);
        end else begin
          tick_d = count[TICK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
      step_q  <= '0;
      hold_q  <= 1'b0;
      tick_q  <= '0;
    end else begin
      color_q <= color_d;
      step_q  <= step_d;
      hold_q  <= hold_d;
      tick_q  <= tick_d;
    end
  end

  assign color_o = color_q;
  assign step_o  = step_q;
  assign hold_o  = hold_q;

endmodule

`default_nettype wire

/* src/rcfs_level.sv */
// Linear interpolation of the three colour components into halved duty levels.
`default_nettype none

module rcfs_level #(
  parameter int unsigned NUM_COLORS = rcfs_pkg::DEF_NUM_COLORS,
  parameter int unsigned FADE_STEPS = rcfs_pkg::DEF_FADE_STEPS,
  localparam int unsigned STEP_W    = $clog2(FADE_STEPS)
) (
  input  wire logic [rcfs_pkg::PAL_W-1:0]     palette_i,
  input  wire logic [rcfs_pkg::COLOR_W-1:0]   color_i,
  input  wire logic [STEP_W-1:0]              step_i,
  output logic [rcfs_pkg::NUM_COMP-1:0][rcfs_pkg::LEVEL_W-1:0] levels_o
);
  import rcfs_pkg::*;

  // step * 1024 / FADE_STEPS by an exact reciprocal (numerator below 2^20)
  localparam int unsigned      NUM_W     = 20;
  localparam int unsigned      RECIP_SH  = NUM_W + $clog2(FADE_STEPS);
  localparam int unsigned      MUL_SHIFT = RECIP_SH - LEVEL_W;
  localparam int unsigned      RECIP_W   = 21;
  localparam longint unsigned  RECIP     =
    ((64'd1 << RECIP_SH) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
  localparam int unsigned      PROD_W    = STEP_W + RECIP_W;
  localparam logic [COLOR_W-1:0] LAST_COLOR = COLOR_W'(NUM_COLORS - 1);

  logic [MAX_COLORS-1:0][NUM_COMP-1:0] pal_rgb;
  logic [COLOR_W-1:0]                  next_color;
  logic [NUM_COMP-1:0]                 from_rgb;
  logic [NUM_COMP-1:0]                 to_rgb;
  logic [PROD_W-1:0]                   prod;
  logic [LEVEL_W-1:0]                  delta;
  logic [SCALE_W-1:0]                  delta_ext;

  assign pal_rgb    = {(PAL_EXT_W-PAL_W)'(0), palette_i};
  assign next_color = (color_i == LAST_COLOR) ? '0 : color_i + COLOR_W'(1);
  assign from_rgb   = pal_rgb[color_i];
  assign to_rgb     = pal_rgb[next_color];

  assign prod      = PROD_W'(step_i) * PROD_W'(RECIP_W'(RECIP));
  assign delta     = prod[MUL_SHIFT +: LEVEL_W];
  assign delta_ext = {1'b0, delta};

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
    logic [SCALE_W-1:0] value;
    always_comb begin
      if (from_rgb[c] == to_rgb[c]) begin
        value = from_rgb[c] ? FULL_SCALE : '0;
      end else if (from_rgb[c]) begin
        value = FULL_SCALE - delta_ext;
      end else begin
        value = delta_ext;
      end
    end
    assign levels_o[c] = value[SCALE_W-1:1];
  end

endmodule

`default_nettype wire
